// File: rtl/kwq_pkg.sv
// kwq_pkg: shared sizes, codes, entry layout and address helpers for the keyed waiting queue.
// No dependencies; imported by the queue top level, its entry RAM user and its checker.
package kwq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_QUEUES  = 2;
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);
    localparam int AW          = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int POS_W       = 5;

    typedef logic [CW-1:0] t_count;
    typedef logic [AW-1:0] t_addr;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] key;
        logic [7:0]  age;
        logic [31:0] phone;
        logic [2:0]  service;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic t_addr f_addr(logic q, t_count idx);
        t_addr base;
        base = q ? t_addr'(QUEUE_DEPTH) : '0;
        return base + t_addr'(idx);
    endfunction

    function automatic logic [POS_W-1:0] f_pos(t_count v);
        logic [CW+POS_W-1:0] ext;
        ext = {{POS_W{1'b0}}, v};
        return ext[POS_W-1:0];
    endfunction

endpackage

// File: rtl/keyed_waiting_queue.sv
// keyed_waiting_queue: top level, request sequencer, queue counters and result register.
// Depends on kwq_pkg and kwq_ram (entry store for both queues).
//
// Two arrival-ordered queues (normal, priority) of QUEUE_DEPTH entries share one entry RAM
// that is walked one entry per cycle through its single read port (a scan pauses on a stalled result).
// Query and a missed remove scan from the newest entry down. A remove that hits stops at
// the newest matching entry, then moves each newer entry down one place to close the gap.
// A query returns one transfer per matching entry, newest first; the scan pauses while the
// result register is full and stalled. One request is in service at a time; the input is
// stalled until its final result is loaded. The RAM needs no clearing after reset.
module keyed_waiting_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_operation,
    input  logic                      i_queue_select,
    input  logic signed [31:0]        i_key,
    input  logic [7:0]                i_age,
    input  logic signed [31:0]        i_phone,
    input  logic [2:0]                i_service_type,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [kwq_pkg::POS_W-1:0] o_position,
    output logic                      o_last
);
    import kwq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_INS   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_SHIFT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_op, n_op;
    logic r_q, n_q;
    t_entry r_entry, n_entry;
    t_count r_cnt [NUM_QUEUES];
    t_count n_cnt [NUM_QUEUES];
    t_count r_rd_cnt, n_rd_cnt;
    logic r_cmp_valid, n_cmp_valid;
    t_count r_cmp_pos, n_cmp_pos;
    logic r_pend_valid, n_pend_valid;
    t_count r_pend_pos, n_pend_pos;
    t_count r_sh_rd, n_sh_rd;
    logic r_wr_valid, n_wr_valid;
    t_count r_wr_idx, n_wr_idx;
    logic r_out_valid, n_out_valid;
    logic [1:0] r_out_status, n_out_status;
    logic [POS_W-1:0] r_out_pos, n_out_pos;
    logic r_out_last, n_out_last;

    logic ram_wr_en, ram_rd_en;
    t_addr ram_wr_addr, ram_rd_addr;
    t_entry ram_wr_data, ram_rd_data;

    logic out_free, match, emit, emit_last;
    t_status emit_status;
    t_count emit_pos, cur_cnt;

    kwq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_QUEUES * QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign cur_cnt  = r_cnt[r_q];
    assign match    = r_cmp_valid && (ram_rd_data.key == r_entry.key);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_q          = r_q;
        n_entry      = r_entry;
        n_cnt        = r_cnt;
        n_rd_cnt     = r_rd_cnt;
        n_cmp_valid  = r_cmp_valid;
        n_cmp_pos    = r_cmp_pos;
        n_pend_valid = r_pend_valid;
        n_pend_pos   = r_pend_pos;
        n_sh_rd      = r_sh_rd;
        n_wr_valid   = r_wr_valid;
        n_wr_idx     = r_wr_idx;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = '0;
        ram_wr_data  = r_entry;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;
        emit         = 1'b0;
        emit_status  = ST_OK;
        emit_pos     = '0;
        emit_last    = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op          = i_operation;
                    n_q           = i_queue_select;
                    n_entry.key   = i_key;
                    n_entry.age   = i_age;
                    n_entry.phone = i_phone;
                    n_entry.service = i_service_type;
                    n_rd_cnt      = r_cnt[i_queue_select];
                    n_cmp_valid   = 1'b0;
                    n_pend_valid  = 1'b0;
                    if (i_operation == OP_INSERT) begin
                        n_state = S_INS;
                    end else if (i_operation == OP_REMOVE || i_operation == OP_QUERY) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_INS: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (cur_cnt == t_count'(QUEUE_DEPTH)) begin
                        emit_status = ST_FULL;
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = f_addr(r_q, cur_cnt);
                        n_cnt[r_q]  = cur_cnt + t_count'(1);
                    end
                end
            end
            S_SCAN: begin
                if (out_free) begin
                    if (r_op == OP_REMOVE && match) begin
                        // hit index is r_cmp_pos - 1; first move reads the entry above it
                        n_state    = S_SHIFT;
                        n_sh_rd    = r_cmp_pos;
                        n_wr_valid = 1'b0;
                    end else if (!r_cmp_valid && r_rd_cnt == '0) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                        if (r_pend_valid) begin
                            emit_pos = r_pend_pos;
                        end else begin
                            emit_status = ST_NOT_FOUND;
                        end
                    end else begin
                        if (r_rd_cnt != '0) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = f_addr(r_q, r_rd_cnt - t_count'(1));
                            n_rd_cnt    = r_rd_cnt - t_count'(1);
                            n_cmp_valid = 1'b1;
                            n_cmp_pos   = r_rd_cnt;
                        end else begin
                            n_cmp_valid = 1'b0;
                        end
                        if (match) begin
                            // older match found: earlier one is not the final transfer
                            if (r_pend_valid) begin
                                emit      = 1'b1;
                                emit_pos  = r_pend_pos;
                                emit_last = 1'b0;
                            end
                            n_pend_valid = 1'b1;
                            n_pend_pos   = r_cmp_pos;
                        end
                    end
                end
            end
            S_SHIFT: begin
                if (r_wr_valid) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = f_addr(r_q, r_wr_idx);
                    ram_wr_data = ram_rd_data;
                end
                if (r_sh_rd < cur_cnt) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = f_addr(r_q, r_sh_rd);
                    n_sh_rd     = r_sh_rd + t_count'(1);
                    n_wr_valid  = 1'b1;
                    n_wr_idx    = r_sh_rd - t_count'(1);
                end else begin
                    n_wr_valid = 1'b0;
                    if (!r_wr_valid && out_free) begin
                        emit       = 1'b1;
                        n_cnt[r_q] = cur_cnt - t_count'(1);
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_last   = r_out_last;
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_status = emit_status;
            n_out_pos    = f_pos(emit_pos);
            n_out_last   = emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '{default: '0};
            r_cmp_valid <= 1'b0;
            r_pend_valid <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_cmp_valid <= n_cmp_valid;
            r_pend_valid <= n_pend_valid;
            r_wr_valid  <= n_wr_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_q          <= n_q;
        r_entry      <= n_entry;
        r_rd_cnt     <= n_rd_cnt;
        r_cmp_pos    <= n_cmp_pos;
        r_pend_pos   <= n_pend_pos;
        r_sh_rd      <= n_sh_rd;
        r_wr_idx     <= n_wr_idx;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_last   <= n_out_last;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_position  = r_out_pos;
    assign o_last      = r_out_last;

endmodule

// File: rtl/kwq_ram.sv
// kwq_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies; used for the entry store of the keyed waiting queue.
module kwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/kwq_checker.sv
// kwq_port_checks: port-level assertions for keyed_waiting_queue, bound to the top level.
// Depends on kwq_pkg for status and operation codes.
module kwq_port_checks (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic [1:0]                i_operation,
    input logic                      i_queue_select,
    input logic signed [31:0]        i_key,
    input logic [7:0]                i_age,
    input logic signed [31:0]        i_phone,
    input logic [2:0]                i_service_type,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [1:0]                o_status,
    input logic [kwq_pkg::POS_W-1:0] o_position,
    input logic                      o_last
);
    import kwq_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall &&
         (i_operation == OP_INSERT || i_operation == OP_REMOVE || i_operation == OP_QUERY))
        |=> o_in_stall)
        else $error("request transfer did not hold off the next one");

    a_full_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_last && o_position == '0))
        else $error("full result not final or carries a position");

    a_miss_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_NOT_FOUND) |-> (o_last && o_position == '0))
        else $error("not-found result not final or carries a position");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_status) && $stable(o_position) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind keyed_waiting_queue kwq_port_checks u_kwq_port_checks (.*);

// File: tb/kwq_checker.sv
`timescale 1ns / 100ps
// kwq_checker: watches both channels of keyed_waiting_queue, tracks its two queues and
// compares every result transfer with the predicted one. Depends on kwq_pkg.
module kwq_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [1:0]                i_operation,
    input  logic                      i_queue_select,
    input  logic [31:0]               i_key,
    input  logic [7:0]                i_age,
    input  logic [31:0]               i_phone,
    input  logic [2:0]                i_service_type,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [1:0]                i_status,
    input  logic [kwq_pkg::POS_W-1:0] i_position,
    input  logic                      i_last,
    output int                        o_fail_count,
    output int                        o_pending
);
    import kwq_pkg::*;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] position;
        logic             last;
    } t_result;

    t_entry  waiting [NUM_QUEUES][QUEUE_DEPTH];
    int      held    [NUM_QUEUES];
    t_result results_due[$];
    int      fails = 0;

    task automatic apply_request(input logic [1:0] op, input logic q, input t_entry ent);
        int n;
        int hit;
        int match_total;
        int sent;
        n           = held[q];
        hit         = -1;
        match_total = 0;
        sent        = 0;
        case (op)
            OP_INSERT: begin
                if (n >= QUEUE_DEPTH) begin
                    results_due.push_back('{ST_FULL, '0, 1'b1});
                end else begin
                    waiting[q][n] = ent;
                    held[q]       = n + 1;
                    results_due.push_back('{ST_OK, '0, 1'b1});
                end
            end
            OP_REMOVE: begin
                for (int i = n - 1; i >= 0 && hit < 0; i--) begin
                    if (waiting[q][i].key == ent.key) hit = i;
                end
                if (hit < 0) begin
                    results_due.push_back('{ST_NOT_FOUND, '0, 1'b1});
                end else begin
                    for (int i = hit; i + 1 < n; i++) waiting[q][i] = waiting[q][i + 1];
                    held[q] = n - 1;
                    results_due.push_back('{ST_OK, '0, 1'b1});
                end
            end
            OP_QUERY: begin
                for (int i = 0; i < n; i++) begin
                    if (waiting[q][i].key == ent.key) match_total++;
                end
                if (match_total == 0) begin
                    results_due.push_back('{ST_NOT_FOUND, '0, 1'b1});
                end else begin
                    // newest match first, rank 1 is the oldest entry
                    for (int i = n - 1; i >= 0; i--) begin
                        if (waiting[q][i].key == ent.key) begin
                            sent++;
                            results_due.push_back('{ST_OK, POS_W'(i + 1), sent == match_total});
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            held = '{default: 0};
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result transfer: status %0d position %0d last %0d",
                           i_status, i_position, i_last);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fails++;
                    end
                    if (i_position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, i_position);
                        fails++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_request(i_operation, i_queue_select,
                              t_entry'{i_key, i_age, i_phone, i_service_type});
            end
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for keyed_waiting_queue; directed cases, then random traffic
// with random gaps and stalls on both sides. Depends on kwq_pkg and kwq_checker.
module tb_top;
    import kwq_pkg::*;

    localparam logic [1:0] OP_IGNORED   = 2'd3;
    localparam int         MAX_GAP      = 11;
    localparam int         BURST_LEN    = 25;
    localparam int         NUM_BURSTS   = 5;
    localparam int         DRAIN_CYCLES = 80;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             in_valid       = 1'b0;
    logic             in_stall;
    logic [1:0]       operation      = OP_INSERT;
    logic             queue_select   = 1'b0;
    logic [31:0]      key            = '0;
    logic [7:0]       age            = '0;
    logic [31:0]      phone          = '0;
    logic [2:0]       service_type   = '0;
    logic             out_valid;
    logic             out_stall      = 1'b0;
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic             last;
    int               fail_count;
    int               pending;
    logic             send_quiet     = 1'b0;
    logic             take_quiet     = 1'b0;
    logic [31:0]      key_pool[4];

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    keyed_waiting_queue i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (operation),
        .i_queue_select (queue_select),
        .i_key          (key),
        .i_age          (age),
        .i_phone        (phone),
        .i_service_type (service_type),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_position     (position),
        .o_last         (last)
    );

    kwq_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_operation    (operation),
        .i_queue_select (queue_select),
        .i_key          (key),
        .i_age          (age),
        .i_phone        (phone),
        .i_service_type (service_type),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_status       (status),
        .i_position     (position),
        .i_last         (last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    task automatic send_item(input logic [1:0] op, input logic q, input logic [31:0] k,
                             input logic [7:0] a, input logic [31:0] p, input logic [2:0] s);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        queue_select <= q;
        key          <= k;
        age          <= a;
        phone        <= p;
        service_type <= s;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return key_pool[$urandom_range(0, 3)];
        endcase
    endfunction

    // result side: each transfer is preceded by a random stall, unless take_quiet is set
    initial begin
        int hold;
        forever begin
            hold = take_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    initial begin
        int         fill;
        int         pick;
        logic [1:0] op;
        for (int i = 0; i < 4; i++) key_pool[i] = $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // normal queue: extremes, duplicate keys, misses, newest-first removal
        send_item(OP_INSERT, 1'b0, 32'h8000_0000, 8'h00, 32'h8000_0000, 3'd0);
        send_item(OP_INSERT, 1'b0, 32'h7fff_ffff, 8'hff, 32'h7fff_ffff, 3'd7);
        send_item(OP_INSERT, 1'b0, 32'h8000_0000, 8'h5a, 32'hffff_ffff, 3'd4);
        send_item(OP_QUERY,  1'b0, 32'h8000_0000, 8'h00, 32'h0, 3'd0);
        send_item(OP_QUERY,  1'b0, 32'd5,         8'h00, 32'h0, 3'd0);
        send_item(OP_REMOVE, 1'b0, 32'd5,         8'h00, 32'h0, 3'd0);
        send_item(OP_REMOVE, 1'b0, 32'h8000_0000, 8'h00, 32'h0, 3'd0);
        send_item(OP_QUERY,  1'b0, 32'h8000_0000, 8'h00, 32'h0, 3'd0);
        send_item(OP_IGNORED, 1'b0, 32'h8000_0000, 8'hff, 32'hffff_ffff, 3'd7);

        // priority queue: fill with one key, overflow, then the widest query
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            send_item(OP_INSERT, 1'b1, 32'h0, 8'($urandom), $urandom, 3'($urandom_range(1, 4)));
        end
        send_item(OP_INSERT, 1'b1, 32'h0, 8'h11, 32'h1234_5678, 3'd2);
        send_item(OP_QUERY,  1'b1, 32'h0, 8'h00, 32'h0, 3'd0);
        wait_until_drained();

        for (int b = 0; b < NUM_BURSTS; b++) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            take_quiet = ($urandom_range(0, 3) == 0);
            fill       = $urandom_range(20, 80);
            for (int n = 0; n < BURST_LEN; n++) begin
                pick = $urandom_range(0, 19);
                if ($urandom_range(0, 99) < fill) op = OP_INSERT;
                else if (pick == 0)               op = OP_IGNORED;
                else if (pick < 9)                op = OP_REMOVE;
                else                              op = OP_QUERY;
                send_item(op, 1'($urandom_range(0, 1)), pick_key(), 8'($urandom), $urandom,
                          3'($urandom_range(0, 7)));
            end
            if (b == 2) wait_until_drained();
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** keyed_waiting_queue: PASSED **");
        end else begin
            $display("** keyed_waiting_queue: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** keyed_waiting_queue: FAILED **");
        $finish;
    end

endmodule
